### hdl/unix_seconds_to_calendar_core_macros.svh
// Assertion helpers for the unix_seconds_to_calendar_core design.
// Synthesis builds see empty bodies.
`ifndef UNIX_SECONDS_TO_CALENDAR_CORE_MACROS_SVH
`define UNIX_SECONDS_TO_CALENDAR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define USC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset
`define USC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define USC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define USC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/uscal_pkg.sv
package uscal_pkg;

    // Reset value of the zone offset register
    localparam logic [3:0] ZONE_RESET = 4'd8;

    // Reciprocal constants: q = (x * RCP) >> shift, exact over each stage's input range
    // x / 15 for x < 2^30, shift 34
    localparam logic [30:0] RCP_DIV15_W30 = 31'd1145324613;
    // x / 15 for x < 2^25, shift 29
    localparam logic [25:0] RCP_DIV15_W25 = 26'd35791395;
    // x / 3 for x < 2^18, shift 20
    localparam logic [18:0] RCP_DIV3_W18  = 19'd349526;
    // x / 1461 for x < 2^16, shift 27
    localparam logic [16:0] RCP_DIV1461   = 17'd91868;
    // x / 365 for x < 2^16, shift 25
    localparam logic [16:0] RCP_DIV365    = 17'd91930;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;
    // First year of a cycle's final (leap) year, taken as 1970 + 2
    localparam logic [11:0] LEAP_CYCLE_YEAR = 12'd1972;
    localparam logic [8:0]  LEAP_DAY_DOY = 9'd60;

    // Day of year before the first of each month, common year
    localparam logic [8:0] MONTH_START [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Second and minute of the hour, total hours, plus whole days since the epoch
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [20:0] hours;
        logic [15:0] days;
    } t_tod;

    // Finished calendar result
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cal;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
    } t_md;

    // Month and day of month from day of year (1..365, common-year layout)
    function automatic t_md month_from_doy(input logic [8:0] doy);
        t_md res;
        res.month = 4'd1;
        res.day   = doy[4:0];
        for (int i = 0; i < 12; i++) begin
            if (MONTH_START[i] < doy) begin
                res.month = 4'(i + 1);
                res.day   = 5'(doy - MONTH_START[i]);
            end
        end
        return res;
    endfunction

endpackage

### hdl/uscal_tsplit.sv
// Four-stage pipe: zone add, then sec / min / hour / day split by reciprocal multiply
module uscal_tsplit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_zone,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_secs,
    output logic              o_valid,
    input  logic              i_ready,
    output uscal_pkg::t_tod   o_tod
);

    logic        r1_v, r2_v, r3_v, r4_v;
    logic        w_adv1, w_adv2, w_adv3, w_adv4;

    logic [31:0] r1_s;
    logic [31:0] r2_s;
    logic [26:0] r2_q;
    logic [5:0]  r3_sec;
    logic [26:0] r3_mins;
    logic [20:0] r3_hours;
    logic [5:0]  r4_sec;
    logic [5:0]  r4_min;
    logic [20:0] r4_hours;
    logic [15:0] r4_days;

    logic [31:0] n1_s;
    logic [60:0] w_p1;
    logic [31:0] w_sec_t;
    logic [50:0] w_p2;
    logic [26:0] w_min_t;
    logic [36:0] w_p3;

    // Each stage moves when empty or when the next one moves
    assign w_adv4  = !r4_v || i_ready;
    assign w_adv3  = !r3_v || w_adv4;
    assign w_adv2  = !r2_v || w_adv3;
    assign w_adv1  = !r1_v || w_adv2;
    assign o_ready = w_adv1;

    // Stage 1: apply zone offset, wraps at 2^32
    assign n1_s = i_secs + 32'(i_zone) * 32'd3600;

    // Stage 2: total minutes = s / 60 = (s >> 2) / 15
    assign w_p1 = 61'(r1_s[31:2]) * 61'(uscal_pkg::RCP_DIV15_W30);

    // Stage 3: seconds remainder, total hours = minutes / 60
    assign w_sec_t = r2_s - 32'(r2_q) * 32'd60;
    assign w_p2    = 51'(r2_q[26:2]) * 51'(uscal_pkg::RCP_DIV15_W25);

    // Stage 4: minutes remainder, whole days = hours / 24 = (hours >> 3) / 3
    assign w_min_t = r3_mins - 27'(r3_hours) * 27'd60;
    assign w_p3    = 37'(r3_hours[20:3]) * 37'(uscal_pkg::RCP_DIV3_W18);

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_adv1) r1_v <= i_valid;
            if (w_adv2) r2_v <= r1_v;
            if (w_adv3) r3_v <= r2_v;
            if (w_adv4) r4_v <= r3_v;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_s <= n1_s;
        end
        if (w_adv2) begin
            r2_s <= r1_s;
            r2_q <= w_p1[60:34];
        end
        if (w_adv3) begin
            r3_sec   <= w_sec_t[5:0];
            r3_mins  <= r2_q;
            r3_hours <= w_p2[49:29];
        end
        if (w_adv4) begin
            r4_sec   <= r3_sec;
            r4_min   <= w_min_t[5:0];
            r4_hours <= r3_hours;
            r4_days  <= w_p3[35:20];
        end
    end

    assign o_valid      = r4_v;
    assign o_tod.second = r4_sec;
    assign o_tod.minute = r4_min;
    assign o_tod.hours  = r4_hours;
    assign o_tod.days   = r4_days;

endmodule

### hdl/uscal_date.sv
`include "unix_seconds_to_calendar_core_macros.svh"

// Three-stage pipe: hour remainder and leap cycle, year, then month/day into the result register
module uscal_date (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  uscal_pkg::t_tod   i_tod,
    output logic              o_valid,
    input  logic              i_ready,
    output uscal_pkg::t_cal   o_cal
);

    logic        r5_v, r6_v, r_o_v;
    logic        w_adv5, w_adv6, w_adv7;

    logic [5:0]  r5_sec, r5_min;
    logic [4:0]  r5_hr;
    logic [15:0] r5_days;
    logic [5:0]  r5_cyc;

    logic [5:0]  r6_sec, r6_min;
    logic [4:0]  r6_hr;
    logic [5:0]  r6_cyc;
    logic        r6_special;
    logic [15:0] r6_d2;
    logic [7:0]  r6_y;

    uscal_pkg::t_cal r_cal;
    uscal_pkg::t_cal n_cal;

    logic [20:0] w_hr_t;
    logic [16:0] w_t5;
    logic [33:0] w_p4;
    logic [16:0] w_t6;
    logic [16:0] w_rem;
    logic [15:0] w_d2;
    logic [32:0] w_p5;
    logic [15:0] w_doy_t;
    logic [8:0]  w_doy;
    logic [8:0]  w_doy_adj;
    logic        w_leap;
    uscal_pkg::t_md w_md;

    assign w_adv7  = !r_o_v || i_ready;
    assign w_adv6  = !r6_v || w_adv7;
    assign w_adv5  = !r5_v || w_adv6;
    assign o_ready = w_adv5;

    // Stage 5: hour of day, four-year cycle index = (days + 365) / 1461
    assign w_hr_t = i_tod.hours - 21'(i_tod.days) * 21'd24;
    assign w_t5   = 17'(i_tod.days) + 17'd365;
    assign w_p4   = 34'(w_t5) * 34'(uscal_pkg::RCP_DIV1461);

    // Stage 6: last day of a cycle when (days + 365) mod 1461 is 1460; years = (days - cyc) / 365
    assign w_t6  = 17'(r5_days) + 17'd365;
    assign w_rem = w_t6 - 17'(r5_cyc) * 17'd1461;
    assign w_d2  = r5_days - 16'(r5_cyc);
    assign w_p5  = 33'(w_d2) * 33'(uscal_pkg::RCP_DIV365);

    // Stage 7: day of year, leap day handling and month lookup
    assign w_doy_t   = r6_d2 - 16'(r6_y) * 16'd365 + 16'd1;
    assign w_doy     = w_doy_t[8:0];
    // 1970 + y divisible by four
    assign w_leap    = (r6_y[1:0] == 2'd2);
    assign w_doy_adj = (w_leap && (w_doy > uscal_pkg::LEAP_DAY_DOY)) ? (w_doy - 9'd1) : w_doy;
    assign w_md      = uscal_pkg::month_from_doy(w_doy_adj);

    always_comb begin
        n_cal.second = r6_sec;
        n_cal.minute = r6_min;
        n_cal.hour   = r6_hr;
        if (r6_special) begin
            // 31 December of the cycle's leap year
            n_cal.year  = uscal_pkg::LEAP_CYCLE_YEAR + 12'({r6_cyc, 2'b00});
            n_cal.month = 4'd12;
            n_cal.day   = 5'd31;
        end else begin
            n_cal.year = uscal_pkg::EPOCH_YEAR + 12'(r6_y);
            if (w_leap && (w_doy == uscal_pkg::LEAP_DAY_DOY)) begin
                n_cal.month = 4'd2;
                n_cal.day   = 5'd29;
            end else begin
                n_cal.month = w_md.month;
                n_cal.day   = w_md.day;
            end
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_adv5) r5_v  <= i_valid;
            if (w_adv6) r6_v  <= r5_v;
            if (w_adv7) r_o_v <= r6_v;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv5) begin
            r5_sec  <= i_tod.second;
            r5_min  <= i_tod.minute;
            r5_hr   <= w_hr_t[4:0];
            r5_days <= i_tod.days;
            r5_cyc  <= w_p4[32:27];
        end
        if (w_adv6) begin
            r6_sec     <= r5_sec;
            r6_min     <= r5_min;
            r6_hr      <= r5_hr;
            r6_cyc     <= r5_cyc;
            r6_special <= (w_rem == 17'd1460);
            r6_d2      <= w_d2;
            r6_y       <= w_p5[32:25];
        end
        if (w_adv7) begin
            r_cal <= n_cal;
        end
    end

    assign o_valid = r_o_v;
    assign o_cal   = r_cal;

    // Checks
    `USC_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, r_o_v && !i_ready, r_o_v && $stable(r_cal))
    `USC_ASSERT_IMP(a_time_range, i_clk, i_rst_n, r_o_v, (r_cal.second < 6'd60) && (r_cal.minute < 6'd60) && (r_cal.hour < 5'd24))
    `USC_ASSERT_IMP(a_date_range, i_clk, i_rst_n, r_o_v, (r_cal.month >= 4'd1) && (r_cal.month <= 4'd12) && (r_cal.day >= 5'd1))
    `USC_ASSERT_IMP(a_leap_day, i_clk, i_rst_n, r_o_v && (r_cal.month == 4'd2) && (r_cal.day == 5'd29), r_cal.year[1:0] == 2'b00)

endmodule

### hdl/unix_seconds_to_calendar_core.sv
// Converts a 32-bit Unix second count to local calendar time (second, minute,
// hour, day, month, year), after adding the zone offset register in whole hours
// (reset 8, wraps modulo 2^32). Every year divisible by four counts as a leap
// year, 2100 included. The block takes one transfer per clock unless output
// back-pressure holds it, and keeps each in a seven-stage pipeline; the depth
// is set by the chain of reciprocal multipliers that replace the divisions by
// 60, 60, 24, 1461 and 365, each followed by a register. Back-pressure stalls
// only the stages that are full. The offset register should be written only
// while nothing is in flight.
module unix_seconds_to_calendar_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Zone offset register
    input  logic        i_cfg_wen,
    input  logic [3:0]  i_cfg_wdata,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] unix_seconds
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                     // [21:17] day, [25:22] month, [37:26] year, rest 0
);

    logic [3:0]        r_zone;
    logic              w_mid_v;
    logic              w_mid_rdy;
    uscal_pkg::t_tod   w_tod;
    uscal_pkg::t_cal   w_cal;

    // Zone offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= uscal_pkg::ZONE_RESET;
        end else if (i_cfg_wen) begin
            r_zone <= i_cfg_wdata;
        end
    end

    uscal_tsplit u_tsplit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_zone  (r_zone),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_secs  (i_s_tdata),
        .o_valid (w_mid_v),
        .i_ready (w_mid_rdy),
        .o_tod   (w_tod)
    );

    uscal_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_v),
        .o_ready (w_mid_rdy),
        .i_tod   (w_tod),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_cal   (w_cal)
    );

    // Pack result fields, lowest first
    assign o_m_tdata = {2'b00, w_cal.year, w_cal.month, w_cal.day,
                        w_cal.hour, w_cal.minute, w_cal.second};

endmodule
